// File: rtl/hpg_pkg.sv
// package for the ham palette grey converter
// holds geometry, command, ham, grey method, config codes and reciprocals
// no dependencies
package hpg_pkg;

    // palette store geometry
    localparam int PAL_ENTRIES = 32;
    localparam int PAL_AW      = 5;
    localparam int COLOR_W     = 12;

    // item commands
    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    // hold-and-modify actions, top two code bits
    typedef enum logic [1:0] {
        HAM_SET   = 2'b00,
        HAM_BLUE  = 2'b01,
        HAM_RED   = 2'b10,
        HAM_GREEN = 2'b11
    } t_ham_op;

    // grey reduction methods
    typedef enum logic [2:0] {
        GREY_AVG   = 3'd0,
        GREY_LUMA  = 3'd1,
        GREY_NEAR  = 3'd2,
        GREY_RED   = 3'd3,
        GREY_GREEN = 3'd4,
        GREY_BLUE  = 3'd5
    } t_grey_method;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GREY_METHOD   = 2'd0,
        CFG_HAM_MODE      = 2'd1,
        CFG_PALETTE_COUNT = 2'd2
    } t_cfg_index;

    // reciprocal multipliers: x/3 for x < 128, x/100 for x < 4096
    localparam logic [5:0]  RECIP3   = 6'd43;
    localparam int          RECIP3_SH = 7;
    localparam logic [10:0] RECIP100 = 11'd1311;
    localparam int          RECIP100_SH = 17;

endpackage

// File: rtl/ham_palette_grey_converter.sv
// top level of the ham palette grey converter
// palette memory, held colour, grey reduction and output register
// depends on hpg_pkg
//
// usage
// - input channel (i_in_valid / o_in_stall) takes load and pixel transactions;
//   a load writes one palette entry, a pixel yields one grey level
// - output channel (o_out_valid / i_out_stall) delivers grey levels in order
// - configuration channel (i_cfg_valid / o_cfg_ready) is always ready; the
//   user must write it only while the block is idle; the block does not enforce this
// - a load needs no further step; a pixel holds the input through the
//   registered palette memory read and the colour resolve step
//   that also updates the held colour, after which the input is free again
// - a pixel passes the resolve stage, grey stage and output register to
//   o_out_valid; a stage waits while the next is full and stalled, and a new
//   pixel is not taken until the held-colour read-modify-write is done
// - reset clears configuration, the held colour and the palette valid bits,
//   so every entry reads as black until loaded; no clearing pass is needed
// - when the receiver stalls, the result holds in the output register, one
//   more waits in the grey stage, a pixel in resolve and o_in_stall stays high
module ham_palette_grey_converter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_cmd,
    input  logic [4:0]              i_entry_index,
    input  logic [7:0]              i_red_in,
    input  logic [7:0]              i_green_in,
    input  logic [7:0]              i_blue_in,
    input  logic [5:0]              i_pixel_code,
    input  logic                    i_row_start,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [4:0]              o_grey_level,
    // configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [5:0]              i_cfg_data
);
    import hpg_pkg::*;

    // configuration registers
    logic [2:0]  r_grey_method;
    logic        r_ham_mode;
    logic [5:0]  r_palette_count;

    // palette memory and per-entry valid bits
    logic [COLOR_W-1:0]     r_pal_mem [0:PAL_ENTRIES-1];
    logic [PAL_ENTRIES-1:0] r_pal_vld;
    logic [COLOR_W-1:0]     r_rd_data;
    logic                   r_rd_ok;

    // resolve stage: pixel waiting for its memory data
    logic        r_a_valid;
    logic [5:0]  r_a_code;
    logic        r_a_row;

    // held colour
    logic [3:0]  r_held_r, r_held_g, r_held_b;

    // grey stage
    logic        r_b_valid;
    logic [3:0]  r_b_r, r_b_g, r_b_b;
    logic [5:0]  r_b_sum;
    logic [10:0] r_b_luma;

    // output register
    logic        r_out_valid;
    logic [4:0]  r_out_grey;

    // handshake and flow
    logic in_acc, out_free, b_move, b_free, a_move;
    logic is_load, is_pixel;
    logic [PAL_AW-1:0] rd_addr;
    logic [5:0] wr_idx_ext, rd_idx_ext;

    assign o_in_stall  = r_a_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !r_a_valid;
    assign is_load     = in_acc && (i_cmd == CMD_LOAD);
    assign is_pixel    = in_acc && (i_cmd == CMD_PIXEL);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign b_move      = r_b_valid && out_free;
    assign b_free      = !r_b_valid || out_free;
    assign a_move      = r_a_valid && b_free;

    // read address: low nibble in ham mode, low five bits otherwise
    assign rd_addr    = r_ham_mode ? {1'b0, i_pixel_code[3:0]} : i_pixel_code[PAL_AW-1:0];
    assign wr_idx_ext = {1'b0, i_entry_index};
    assign rd_idx_ext = {1'b0, rd_addr};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grey_method   <= GREY_AVG;
            r_ham_mode      <= 1'b0;
            r_palette_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GREY_METHOD:   r_grey_method   <= i_cfg_data[2:0];
                CFG_HAM_MODE:      r_ham_mode      <= i_cfg_data[0];
                CFG_PALETTE_COUNT: r_palette_count <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (is_load && (wr_idx_ext < 6'(PAL_ENTRIES))) begin
            r_pal_mem[i_entry_index] <= {i_red_in[7:4], i_green_in[7:4], i_blue_in[7:4]};
        end
        if (is_pixel) begin
            r_rd_data <= r_pal_mem[rd_addr];
        end
    end

    // valid bits and read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (is_load && (wr_idx_ext < 6'(PAL_ENTRIES))) begin
                r_pal_vld[i_entry_index] <= 1'b1;
            end
            if (is_pixel) begin
                r_rd_ok <= (rd_idx_ext < 6'(PAL_ENTRIES)) && r_pal_vld[rd_addr];
            end
        end
    end

    // pixel fields for the resolve step
    always_ff @(posedge i_clk) begin
        if (is_pixel) begin
            r_a_code <= i_pixel_code;
            r_a_row  <= i_row_start;
        end
    end

    // colour resolve: row start clear, then palette or hold-and-modify
    logic [COLOR_W-1:0] entry;
    logic [3:0] base_r, base_g, base_b;
    logic [3:0] n_held_r, n_held_g, n_held_b;
    logic [3:0] col_r, col_g, col_b;
    logic [5:0] n_sum;
    logic [10:0] n_luma;

    always_comb begin
        entry  = r_rd_ok ? r_rd_data : '0;
        base_r = r_a_row ? 4'd0 : r_held_r;
        base_g = r_a_row ? 4'd0 : r_held_g;
        base_b = r_a_row ? 4'd0 : r_held_b;
        n_held_r = base_r;
        n_held_g = base_g;
        n_held_b = base_b;
        if (r_ham_mode) begin
            case (r_a_code[5:4])
                HAM_SET: begin
                    n_held_r = entry[11:8];
                    n_held_g = entry[7:4];
                    n_held_b = entry[3:0];
                end
                HAM_BLUE:  n_held_b = r_a_code[3:0];
                HAM_RED:   n_held_r = r_a_code[3:0];
                HAM_GREEN: n_held_g = r_a_code[3:0];
                default:   ;
            endcase
            col_r = n_held_r;
            col_g = n_held_g;
            col_b = n_held_b;
        end else begin
            col_r = entry[11:8];
            col_g = entry[7:4];
            col_b = entry[3:0];
        end
        n_sum  = 6'(col_r) + 6'(col_g) + 6'(col_b);
        n_luma = 11'(col_r) * 11'd30 + 11'(col_g) * 11'd59 + 11'(col_b) * 11'd11;
    end

    // resolve stage control, held colour and grey stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_held_r  <= '0;
            r_held_g  <= '0;
            r_held_b  <= '0;
        end else begin
            if (is_pixel) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
                r_held_r  <= n_held_r;
                r_held_g  <= n_held_g;
                r_held_b  <= n_held_b;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_r    <= col_r;
            r_b_g    <= col_g;
            r_b_b    <= col_b;
            r_b_sum  <= n_sum;
            r_b_luma <= n_luma;
        end
    end

    // grey reduction
    logic [11:0] avg_prod, near_prod;
    logic [21:0] luma_prod;
    logic [4:0]  near_round, near_top, n_grey;

    always_comb begin
        avg_prod   = 12'(r_b_sum) * 12'(RECIP3);
        near_prod  = 12'(r_b_sum + 6'd1) * 12'(RECIP3);
        luma_prod  = 22'(r_b_luma) * 22'(RECIP100);
        // nearest level is the rounded third of the sum, ties low, capped
        near_round = near_prod[RECIP3_SH +: 5];
        near_top   = 5'(r_palette_count - 6'd1);
        case (r_grey_method)
            GREY_AVG:   n_grey = avg_prod[RECIP3_SH +: 5];
            GREY_LUMA:  n_grey = luma_prod[RECIP100_SH +: 5];
            GREY_NEAR: begin
                if (r_palette_count == 6'd0) begin
                    n_grey = 5'd0;
                end else if ({1'b0, near_round} >= r_palette_count) begin
                    n_grey = near_top;
                end else begin
                    n_grey = near_round;
                end
            end
            GREY_RED:   n_grey = {1'b0, r_b_r};
            GREY_GREEN: n_grey = {1'b0, r_b_g};
            GREY_BLUE:  n_grey = {1'b0, r_b_b};
            default:    n_grey = 5'd0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_out_grey <= n_grey;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_grey_level = r_out_grey;

endmodule

// File: rtl/hpg_checker.sv
// port-level checker for the ham palette grey converter, with its bind
// watches handshake timing of the top level ports
// depends on hpg_pkg and ham_palette_grey_converter
module hpg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_cmd,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_grey_level
);
    import hpg_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a pixel transaction blocks the input while its colour is resolved
    a_pixel_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_PIXEL)) |=> o_in_stall)
        else $error("input not stalled after pixel transaction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_grey_level)))
        else $error("stalled result changed");

    // a fresh result must match an earlier accepted pixel transaction, sampled through $past
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(in_acc, 3) && ($past(i_cmd, 3) == CMD_PIXEL)))
        else $error("result without matching pixel transaction");

endmodule

bind ham_palette_grey_converter hpg_checker u_hpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_cmd        (i_cmd),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_grey_level (o_grey_level)
);
